FILE: hdl/assert_macros.svh
// Assertion macros shared by the factorizer RTL.
// Assertions drop out entirely when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  `ASSERT_PROP(lbl, clk, rst, !(cond), msg)
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

FILE: hdl/pf_pkg.sv
// Shared types and constants of the prime factorization core.
// No dependencies.
package pf_pkg;

  localparam int IN_W    = 31;  // width of the value input field
  localparam int PRIME_W = 31;  // width of the prime output field
  localparam int EXP_W   = 5;   // width of the exponent output field

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_START  = 5'b00100,
    S_DIVIDE = 5'b01000,
    S_EMIT   = 5'b10000
  } pf_state_t;

endpackage

FILE: hdl/pf_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing; used by prime_factorization_core.
module pf_divider #(
  parameter int W = 31
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);

  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic [CW-1:0] count;
  logic [W:0]    rem_shift;
  logic [W:0]    rem_diff;
  logic          q_bit;

  // One restoring step: shift in next dividend bit, try subtract
  always_comb begin
    rem_shift = {rem, quot[W-1]};
    rem_diff  = rem_shift - {1'b0, divisor};
    q_bit     = !rem_diff[W];  // no borrow: partial remainder covers divisor
  end

  // Control: busy flag, bit counter, done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      count <= CW'(W);
    end else if (busy) begin
      count <= count - CW'(1);
      if (count == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath: partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
    end else if (busy) begin
      rem  <= q_bit ? rem_diff[W-1:0] : rem_shift[W-1:0];
      quot <= {quot[W-2:0], q_bit};
    end
  end

endmodule

FILE: hdl/prime_factorization_core.sv
// Trial-division prime factorizer: sequencer, square tracking, output register.
// Depends on pf_pkg, pf_divider and assert_macros.svh.
//
// Usage:
//   Input channel (value, in_valid, in_stall): a transfer happens when in_valid
//   is high and in_stall is low. in_stall stays high from the accepted value
//   until its last result has been loaded into the output register, and also
//   through the check state when that result came from the trial loop.
//   Output channel (prime, exponent, none_found, out_valid, out_stall): one
//   transfer per distinct prime factor in ascending order, the final one with
//   last set. An input of 0 or 1 gives a single transfer with none_found set.
//   Sequence: every trial divisor d passes through check, start, one divider
//   step per bit and done; each extra division that strips a factor repeats
//   all of these but the check. The shared restoring divider takes the steps
//   one per bit. A prime near 2^31 needs about 46341 divisors.
//   Stall: while out_stall holds a result, the sequencer waits before loading
//   the next one; no result is dropped.
//   Reset: synchronous; returns to idle with the output register empty.
`include "assert_macros.svh"

module prime_factorization_core
  import pf_pkg::*;
#(
  parameter int VALUE_BITS = 31
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [IN_W-1:0]    value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [PRIME_W-1:0] prime,
  output logic [EXP_W-1:0]   exponent,
  output logic               none_found,
  output logic               last
);

  localparam int SQ_W = VALUE_BITS + 2;

  pf_state_t             state;
  logic [VALUE_BITS-1:0] n;
  logic [VALUE_BITS-1:0] d;
  logic [SQ_W-1:0]       sq;
  logic [EXP_W-1:0]      cnt;

  logic [VALUE_BITS-1:0] emit_prime;
  logic [EXP_W-1:0]      emit_exp;
  logic                  emit_none;
  logic                  emit_last;
  logic                  emit_to_idle;

  logic                  in_xfer;
  logic                  out_free;
  logic                  div_start;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [VALUE_BITS-1:0] div_rem;
  logic [VALUE_BITS-1:0] n_load;

  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign div_start = (state == S_START);
  assign n_load    = VALUE_BITS'(value);

  pf_divider #(.W(VALUE_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (n),
    .divisor  (d),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_xfer) state <= (n_load <= VALUE_BITS'(1)) ? S_EMIT : S_CHECK;
        end
        S_CHECK: begin
          if (sq <= SQ_W'(n))        state <= S_START;
          else if (n > VALUE_BITS'(1)) state <= S_EMIT;
          else                       state <= S_IDLE;
        end
        S_START: state <= S_DIVIDE;
        S_DIVIDE: begin
          if (div_done) begin
            if (div_rem == '0)       state <= S_START;
            else if (cnt != '0)      state <= S_EMIT;
            else                     state <= S_CHECK;
          end
        end
        S_EMIT: begin
          if (out_free) state <= emit_to_idle ? S_IDLE : S_CHECK;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Working registers: quotient, trial divisor, its square, multiplicity
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      n   <= n_load;
      d   <= VALUE_BITS'(2);
      sq  <= SQ_W'(4);
      cnt <= '0;
    end else if (state == S_DIVIDE && div_done) begin
      if (div_rem == '0) begin
        n   <= div_quot;
        cnt <= cnt + EXP_W'(1);
      end else begin
        // (d+1)^2 = d^2 + 2d + 1
        d   <= d + VALUE_BITS'(1);
        sq  <= sq + SQ_W'({d, 1'b1});
        cnt <= '0;
      end
    end
  end

  // Pending result to hand to the output register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      emit_prime   <= '0;
      emit_exp     <= '0;
      emit_none    <= 1'b1;
      emit_last    <= 1'b1;
      emit_to_idle <= 1'b1;
    end else if (state == S_CHECK) begin
      emit_prime   <= n;
      emit_exp     <= EXP_W'(1);
      emit_none    <= 1'b0;
      emit_last    <= 1'b1;
      emit_to_idle <= 1'b1;
    end else if (state == S_DIVIDE && div_done && div_rem != '0) begin
      // remaining quotient of one means no further factor follows
      emit_prime   <= d;
      emit_exp     <= cnt;
      emit_none    <= 1'b0;
      emit_last    <= (n == VALUE_BITS'(1));
      emit_to_idle <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      prime      <= PRIME_W'(emit_prime);
      exponent   <= emit_exp;
      none_found <= emit_none;
      last       <= emit_last;
    end
  end

  `ASSERT_PROP(a_none_fields, clk, rst,
    out_valid && none_found |-> last && prime == '0 && exponent == '0,
    "no-factor result carries a prime or exponent")
  `ASSERT_PROP(a_factor_fields, clk, rst,
    out_valid && !none_found |-> exponent != '0 && prime >= PRIME_W'(2),
    "factor result with zero exponent or prime below two")
  `ASSERT_NEVER(a_done_state, clk, rst, div_done && state != S_DIVIDE,
    "divider finished outside the divide state")
  `ASSERT_PROP(a_work_regs, clk, rst,
    (state == S_START || state == S_DIVIDE) |-> d >= VALUE_BITS'(2) && n != '0,
    "division started with bad divisor or zero quotient")

endmodule
